// ----- rtl/core/rfme_pkg.sv -----
// Shared constants and types for the reload fade and mute envelope.
package rfme_pkg;

   // Sample and fade geometry.
   localparam int SAMPLE_BITS  = 24;
   localparam int FADE_SAMPLES = 128;
   localparam int FADE_SHIFT   = $clog2(FADE_SAMPLES);
   localparam int GAIN_BITS    = $clog2(FADE_SAMPLES + 1);
   localparam int HOLD_BITS    = 21;
   localparam int PHASE_BITS   = 2;

   // Full-scale gain, which passes a sample unchanged.
   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(FADE_SAMPLES);

   // Envelope phases, as reported on the result channel.
   localparam logic [PHASE_BITS-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_BITS-1:0] PH_OUT  = 2'd1;
   localparam logic [PHASE_BITS-1:0] PH_HOLD = 2'd2;
   localparam logic [PHASE_BITS-1:0] PH_IN   = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // One frame after the gain has been chosen, ahead of the multiply.
   typedef struct packed {
      sample_type                  left;
      sample_type                  right;
      logic [GAIN_BITS-1:0]        gain;
      logic                        pulse;
      logic [PHASE_BITS-1:0]       phase;
   } frame_type;

endpackage

// ----- rtl/core/rfme_channels.sv -----
// Channel interfaces for the frame input, the result output and the register write.

// Input frame channel.
interface rfme_req_if;
   logic                       valid;
   logic                       ready;
   rfme_pkg::sample_type       left_in;
   rfme_pkg::sample_type       right_in;
   logic                       reload_level;

   modport source (output valid, output left_in, output right_in, output reload_level,
                   input ready);
   modport sink   (input valid, input left_in, input right_in, input reload_level,
                   output ready);
endinterface

// Result frame channel.
interface rfme_rsp_if;
   logic                                  valid;
   logic                                  ready;
   rfme_pkg::sample_type                  left_out;
   rfme_pkg::sample_type                  right_out;
   logic                                  reload_pulse;
   logic [rfme_pkg::PHASE_BITS-1:0]       phase_out;

   modport source (output valid, output left_out, output right_out, output reload_pulse,
                   output phase_out, input ready);
   modport sink   (input valid, input left_out, input right_out, input reload_pulse,
                   input phase_out, output ready);
endinterface

// Register write channel for hold_samples.
interface rfme_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rfme_pkg::HOLD_BITS-1:0]     hold_samples;

   modport source (output valid, output hold_samples, input ready);
   modport sink   (input valid, input hold_samples, output ready);
endinterface

// ----- rtl/core/reload_fade_mute_envelope.sv -----
// Top level of the reload fade and mute envelope for a stereo frame stream.
//
//   Channel   Direction  Contents
//   req_bus   in         left_in, right_in (Q1.23), reload_level
//   rsp_bus   out        left_out, right_out (Q1.23), reload_pulse, phase_out
//   csr_bus   in         hold_samples (21 bits), always ready
//
// One frame is accepted per cycle while rsp_bus takes its results; a frame passes
// through the input stage register and then the result register before it is valid.
// The envelope counters update at acceptance, then one multiply per channel
// sits between the input stage register and the result register.
// Reset clears the phase, counters, level latch and hold_samples, and empties both stages.
// When the result is not taken, the input stage still fills once before req_bus.ready drops.
module reload_fade_mute_envelope (
   input  logic         clock,
   input  logic         reset,
   rfme_req_if.sink     req_bus,
   rfme_rsp_if.source   rsp_bus,
   rfme_csr_if.sink     csr_bus
);

   logic                  stage_valid;
   logic                  stage_advance;
   rfme_pkg::frame_type   stage_frame;
   logic                  req_fire;

   // The input stage takes a beat when empty or when it moves on this cycle.
   assign req_bus.ready = !stage_valid || stage_advance;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   rfme_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_bus.valid),
      .csr_hold      (csr_bus.hold_samples),
      .req_fire      (req_fire),
      .req_left      (req_bus.left_in),
      .req_right     (req_bus.right_in),
      .req_level     (req_bus.reload_level),
      .stage_advance (stage_advance),
      .stage_valid   (stage_valid),
      .stage_frame   (stage_frame)
   );

   rfme_scaler u_scaler (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage_frame   (stage_frame),
      .stage_advance (stage_advance),
      .rsp_bus       (rsp_bus)
   );

endmodule

// ----- rtl/core/rfme_ctrl.sv -----
// Envelope sequencer: edge detection, phase counters, gain choice and the input stage register.
module rfme_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [rfme_pkg::HOLD_BITS-1:0]   csr_hold,
   input  logic                             req_fire,
   input  rfme_pkg::sample_type             req_left,
   input  rfme_pkg::sample_type             req_right,
   input  logic                             req_level,
   input  logic                             stage_advance,
   output logic                             stage_valid,
   output rfme_pkg::frame_type              stage_frame
);

   logic [rfme_pkg::HOLD_BITS-1:0]    hold_samples_ff;
   logic [rfme_pkg::PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [rfme_pkg::GAIN_BITS-1:0]    fade_count_ff, fade_count_in;
   logic [rfme_pkg::HOLD_BITS-1:0]    hold_count_ff, hold_count_in;
   logic                              latch_ff;
   logic                              stage_valid_ff, stage_valid_in;
   rfme_pkg::frame_type               frame_ff, frame_in;

   logic [rfme_pkg::PHASE_BITS-1:0]   cur_phase;
   logic [rfme_pkg::GAIN_BITS-1:0]    cur_fade;
   logic [rfme_pkg::GAIN_BITS-1:0]    fade_dec;
   logic [rfme_pkg::HOLD_BITS-1:0]    hold_dec;
   logic                              start_fade;

   // A rising edge of the level while idle opens a fade-out.
   assign start_fade = req_level && !latch_ff && (phase_ff == rfme_pkg::PH_IDLE);
   assign cur_phase  = start_fade ? rfme_pkg::PH_OUT : phase_ff;
   assign cur_fade   = start_fade ? rfme_pkg::GAIN_UNITY : fade_count_ff;
   assign fade_dec   = (cur_fade != '0) ? cur_fade - 1'b1 : cur_fade;
   assign hold_dec   = (hold_count_ff != '0) ? hold_count_ff - 1'b1 : hold_count_ff;

   // Gain for this frame and the next phase and counter values.
   always_comb begin
      phase_in       = cur_phase;
      fade_count_in  = cur_fade;
      hold_count_in  = hold_count_ff;
      frame_in.left  = req_left;
      frame_in.right = req_right;
      frame_in.gain  = rfme_pkg::GAIN_UNITY;
      frame_in.pulse = 1'b0;
      frame_in.phase = cur_phase;
      unique case (cur_phase)
         rfme_pkg::PH_OUT: begin
            frame_in.gain = cur_fade;
            fade_count_in = fade_dec;
            if (fade_dec == '0) begin
               frame_in.pulse = 1'b1;
               phase_in       = rfme_pkg::PH_HOLD;
               hold_count_in  = hold_samples_ff;
            end
         end
         rfme_pkg::PH_HOLD: begin
            frame_in.gain = '0;
            hold_count_in = hold_dec;
            if (hold_dec == '0) begin
               phase_in      = rfme_pkg::PH_IN;
               fade_count_in = rfme_pkg::GAIN_UNITY;
            end
         end
         rfme_pkg::PH_IN: begin
            frame_in.gain = rfme_pkg::GAIN_UNITY - cur_fade;
            fade_count_in = fade_dec;
            if (fade_dec == '0) begin
               phase_in = rfme_pkg::PH_IDLE;
            end
         end
         default: begin
            frame_in.gain = rfme_pkg::GAIN_UNITY;
         end
      endcase
   end

   // The stage fills on an accepted beat and empties when the scaler takes it.
   assign stage_valid_in = req_fire || (stage_valid_ff && !stage_advance);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_samples_ff <= '0;
         phase_ff        <= rfme_pkg::PH_IDLE;
         fade_count_ff   <= '0;
         hold_count_ff   <= '0;
         latch_ff        <= 1'b0;
         stage_valid_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_write) begin
            hold_samples_ff <= csr_hold;
         end
         if (req_fire) begin
            phase_ff      <= phase_in;
            fade_count_ff <= fade_count_in;
            hold_count_ff <= hold_count_in;
            latch_ff      <= req_level;
         end
      end
   end

   // Frame payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff <= frame_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_frame = frame_ff;

endmodule

// ----- rtl/core/rfme_scaler.sv -----
// Gain multiply for both channels and the result register.
module rfme_scaler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  rfme_pkg::frame_type   stage_frame,
   output logic                  stage_advance,
   rfme_rsp_if.source            rsp_bus
);

   localparam int PROD_BITS = rfme_pkg::SAMPLE_BITS + rfme_pkg::GAIN_BITS + 1;

   logic signed [PROD_BITS-1:0]  left_prod, right_prod;
   logic signed [PROD_BITS-1:0]  left_shift, right_shift;
   logic signed [rfme_pkg::GAIN_BITS:0] gain_s;

   logic                              valid_ff, valid_in;
   rfme_pkg::sample_type              left_ff, right_ff;
   logic                              pulse_ff;
   logic [rfme_pkg::PHASE_BITS-1:0]   phase_ff;

   // Gain is g / FADE_SAMPLES; the arithmetic shift rounds toward minus infinity.
   // Full-scale gain reproduces the sample exactly.
   assign gain_s      = $signed({1'b0, stage_frame.gain});
   assign left_prod   = PROD_BITS'(stage_frame.left) * PROD_BITS'(gain_s);
   assign right_prod  = PROD_BITS'(stage_frame.right) * PROD_BITS'(gain_s);
   assign left_shift  = left_prod >>> rfme_pkg::FADE_SHIFT;
   assign right_shift = right_prod >>> rfme_pkg::FADE_SHIFT;

   // The result register loads when empty or when its beat is taken.
   assign stage_advance = stage_valid && (!valid_ff || rsp_bus.ready);
   assign valid_in      = stage_advance || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_advance) begin
         left_ff  <= left_shift[rfme_pkg::SAMPLE_BITS-1:0];
         right_ff <= right_shift[rfme_pkg::SAMPLE_BITS-1:0];
         pulse_ff <= stage_frame.pulse;
         phase_ff <= stage_frame.phase;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.left_out     = left_ff;
   assign rsp_bus.right_out    = right_ff;
   assign rsp_bus.reload_pulse = pulse_ff;
   assign rsp_bus.phase_out    = phase_ff;

endmodule
